### src/frx_pkg.sv
// ============================================================================
// frx_pkg - shared types and constants of the framed packet receiver
// Field widths, register indexes, controller states and the command/status
// bundles that join the controller and the datapath.
// ============================================================================
package frx_pkg;

    // Largest payload the store holds
    localparam int MAX_PAYLOAD = 16;
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 8;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 2;

    // Result tdata: error_seen, packet_count, payload_index, payload_byte
    localparam int OUT_FIELD_W = 1 + CNT_W + IDX_W + BYTE_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hFF;
    localparam logic [BYTE_W-1:0] TRAILER_RST = 8'hFE;
    localparam logic [LEN_W-1:0]  LENGTH_RST  = 5'd8;

    typedef logic [PAY_AW-1:0] t_pay_idx;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER  = 2'd0,
        CFG_TRAILER = 2'd1,
        CFG_LENGTH  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COLLECT = 2'd1,
        ST_TRAILER = 2'd2,
        ST_EMIT    = 2'd3
    } t_ctl_state;

    typedef struct packed {
        logic in_ready;
        logic clear_pkt;
        logic fill_wr;
        logic err_wr;
        logic start_emit;
        logic emit_step;
        logic status_out;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_hit;
        logic trl_hit;
        logic fill_last;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic              done;
        logic              err;
        logic [CNT_W-1:0]  count;
        t_idx              idx;
        logic [BYTE_W-1:0] pay_byte;
        logic              last;
    } t_result;

endpackage

### src/frx_ctrl.sv
// ============================================================================
// frx_ctrl - framing controller
// Tracks the packet phase (idle, collecting, awaiting trailer) and sequences
// the payload run; issues commands to the datapath.
// ============================================================================
module frx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  frx_pkg::t_dp_stat i_stat,
    output frx_pkg::t_dp_cmd  o_cmd
);

    frx_pkg::t_ctl_state r_state;
    frx_pkg::t_ctl_state n_state;
    logic                in_ready;
    logic                fire;

    assign in_ready = i_stat.out_free && (r_state != frx_pkg::ST_EMIT);
    assign fire     = i_s_tvalid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frx_pkg::ST_IDLE: begin
                if (fire && i_stat.hdr_hit) n_state = frx_pkg::ST_COLLECT;
            end
            frx_pkg::ST_COLLECT: begin
                if (fire && i_stat.fill_last) n_state = frx_pkg::ST_TRAILER;
            end
            frx_pkg::ST_TRAILER: begin
                if (fire && i_stat.trl_hit) n_state = frx_pkg::ST_EMIT;
            end
            frx_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) n_state = frx_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.in_ready = in_ready;
        unique case (r_state)
            frx_pkg::ST_IDLE: begin
                if (fire) begin
                    o_cmd.status_out = 1'b1;
                    o_cmd.clear_pkt  = i_stat.hdr_hit;
                end
            end
            frx_pkg::ST_COLLECT: begin
                if (fire) begin
                    o_cmd.fill_wr    = 1'b1;
                    o_cmd.status_out = 1'b1;
                end
            end
            frx_pkg::ST_TRAILER: begin
                if (fire) begin
                    if (i_stat.trl_hit) begin
                        o_cmd.start_emit = 1'b1;
                    end else begin
                        // wrong byte: overwrite last payload entry, flag error
                        o_cmd.err_wr     = 1'b1;
                        o_cmd.status_out = 1'b1;
                    end
                end
            end
            frx_pkg::ST_EMIT: begin
                o_cmd.emit_step = i_stat.out_free;
            end
        endcase
    end

endmodule

### src/frx_datapath.sv
// ============================================================================
// frx_datapath - payload store, counters and result register
// Holds the configuration, the payload store with per-entry valid bits,
// fill and run counters, the packet counter and the output register.
// ============================================================================
module frx_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr,
    input  logic [frx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frx_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic [frx_pkg::BYTE_W-1:0]        i_rx_byte,
    input  frx_pkg::t_dp_cmd                  i_cmd,
    output frx_pkg::t_dp_stat                 o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output frx_pkg::t_result                  o_result
);

    logic [frx_pkg::BYTE_W-1:0] r_hdr;
    logic [frx_pkg::BYTE_W-1:0] r_trl;
    frx_pkg::t_len              r_len;
    frx_pkg::t_len              eff_len;

    logic [frx_pkg::BYTE_W-1:0]      r_store [frx_pkg::MAX_PAYLOAD];
    logic [frx_pkg::MAX_PAYLOAD-1:0] r_vld;

    frx_pkg::t_len             r_fill;
    frx_pkg::t_len             n_fill;
    frx_pkg::t_len             r_emit_cnt;
    logic                      r_err;
    logic                      n_err;
    logic [frx_pkg::CNT_W-1:0] r_count;

    logic                       wr_en;
    frx_pkg::t_pay_idx          wr_idx;
    frx_pkg::t_pay_idx          rd_idx;
    logic [frx_pkg::BYTE_W-1:0] rd_byte;
    logic                       emit_last;
    logic                       out_load;
    frx_pkg::t_result           n_result;
    logic                       r_out_valid;
    frx_pkg::t_result           r_result;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= frx_pkg::HEADER_RST;
            r_trl <= frx_pkg::TRAILER_RST;
            r_len <= frx_pkg::LENGTH_RST;
        end else if (i_cfg_wr) begin
            unique case (frx_pkg::t_cfg_index'(i_cfg_index))
                frx_pkg::CFG_HEADER:  r_hdr <= i_cfg_data;
                frx_pkg::CFG_TRAILER: r_trl <= i_cfg_data;
                frx_pkg::CFG_LENGTH:  r_len <= frx_pkg::t_len'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Clamp length to 1..MAX_PAYLOAD
    always_comb begin
        if (r_len == '0) begin
            eff_len = frx_pkg::t_len'(1);
        end else if (32'(r_len) > frx_pkg::MAX_PAYLOAD) begin
            eff_len = frx_pkg::t_len'(frx_pkg::MAX_PAYLOAD);
        end else begin
            eff_len = r_len;
        end
    end

    assign n_fill    = r_fill + frx_pkg::t_len'(1);
    assign emit_last = (r_emit_cnt + frx_pkg::t_len'(1)) == eff_len;

    assign o_stat.hdr_hit   = (i_rx_byte == r_hdr);
    assign o_stat.trl_hit   = (i_rx_byte == r_trl);
    assign o_stat.fill_last = (n_fill >= eff_len);
    assign o_stat.emit_last = emit_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Payload store
    assign wr_en  = (i_cmd.fill_wr && (32'(r_fill) < frx_pkg::MAX_PAYLOAD)) || i_cmd.err_wr;
    assign wr_idx = i_cmd.err_wr ? frx_pkg::t_pay_idx'(eff_len - frx_pkg::t_len'(1))
                                 : frx_pkg::t_pay_idx'(r_fill);
    assign rd_idx = frx_pkg::t_pay_idx'(r_emit_cnt);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_idx] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clear_pkt) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    // Entries not written since the header read as zero
    assign rd_byte = r_vld[rd_idx] ? r_store[rd_idx] : '0;

    // Counters and error flag
    always_comb begin
        n_err = r_err;
        if (i_cmd.clear_pkt) begin
            n_err = 1'b0;
        end else if (i_cmd.err_wr) begin
            n_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_emit_cnt <= '0;
            r_err      <= 1'b0;
            r_count    <= '0;
        end else begin
            r_err <= n_err;
            if (i_cmd.clear_pkt) begin
                r_fill <= '0;
            end else if (i_cmd.fill_wr) begin
                r_fill <= n_fill;
            end
            if (i_cmd.start_emit) begin
                r_emit_cnt <= '0;
                r_count    <= r_count + 1'b1;
            end else if (i_cmd.emit_step) begin
                r_emit_cnt <= r_emit_cnt + frx_pkg::t_len'(1);
            end
        end
    end

    // Result register
    always_comb begin
        n_result       = '0;
        n_result.count = r_count;
        if (i_cmd.emit_step) begin
            n_result.done     = 1'b1;
            n_result.err      = r_err;
            n_result.idx      = frx_pkg::t_idx'(r_emit_cnt);
            n_result.pay_byte = rd_byte;
            n_result.last     = emit_last;
        end else begin
            n_result.err  = n_err;
            n_result.last = 1'b1;
        end
    end

    assign out_load = i_cmd.status_out || i_cmd.emit_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### src/framed_packet_receiver.sv
// ============================================================================
// framed_packet_receiver - header/fixed-length/trailer packet receiver
//
// Slave stream: one received byte per transfer on s_tdata. Master stream: one
// result per transfer; tuser marks payload of a completed packet, tlast marks
// the final result caused by an input byte. A separate write channel sets the
// header byte, trailer byte and payload length (always ready).
//
// A byte that is not a trailer closing a packet gives one status result on the
// master side in the cycle after its transfer, and the next byte can be taken
// in that same cycle when the sink takes that result, so such bytes go through
// at one per cycle while the sink keeps up. A trailer that closes a packet
// sends its payload from the store one result per cycle while the sink is
// ready, and the slave side stays not ready until that run has been sent.
//
// The output register decouples the two sides: a new byte is taken while a
// result is still waiting, provided the sink takes it in that same cycle.
// When the sink stalls, the result holds and s_tready drops.
// Synchronous reset restores the default configuration, clears the payload
// valid bits, the error flag and the packet counter, and empties the output.
// ============================================================================
module framed_packet_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: [7:0] rx_byte
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [frx_pkg::BYTE_W-1:0]        i_s_tdata,
    // tdata: [0] error_seen, [8:1] packet_count, [12:9] payload_index,
    //        [20:13] payload_byte, [23:21] zero
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [frx_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: [0] packet_done
    output logic                              o_m_tuser,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [frx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frx_pkg::BYTE_W-1:0]        i_cfg_data
);

    frx_pkg::t_dp_cmd  cmd;
    frx_pkg::t_dp_stat stat;
    frx_pkg::t_result  result;

    assign o_cfg_ready = 1'b1;

    frx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    frx_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_result    (result)
    );

    assign o_s_tready = cmd.in_ready;
    assign o_m_tdata  = {{frx_pkg::OUT_PAD_W{1'b0}}, result.pay_byte, result.idx,
                         result.count, result.err};
    assign o_m_tuser  = result.done;
    assign o_m_tlast  = result.last;

endmodule

### src/frx_checker.sv
// ============================================================================
// frx_checker - port-level checks for the framed packet receiver
// Watches the top-level streams for result shape, run behavior and reset.
// ============================================================================
module frx_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [frx_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input logic                              o_m_tuser,
    input logic                              o_m_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // A status result is a single transfer with no payload
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && (o_m_tdata[20:9] == '0))
        else $error("status result carries payload or is not last");

    // No byte is taken while a payload run is still being sent
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && !o_m_tlast |-> !o_s_tready)
        else $error("input accepted during payload run");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind framed_packet_receiver frx_checker u_frx_checker (.*);

### verif/frx_result_checker.sv
// ============================================================================
// frx_result_checker - result predictor and comparator for the packet receiver
// Follows register writes and accepted bytes, keeps its own copy of the
// framing state, queues the results each byte must cause and compares every
// master-side transfer, field by field, against the oldest queued result.
// ============================================================================
module frx_result_checker
    import frx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0]     i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_bytes_seen,
    output int                    o_results_seen,
    output int                    o_packets_seen,
    output int                    o_cfg_writes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 50;

    logic [BYTE_W-1:0] hdr_value;
    logic [BYTE_W-1:0] trl_value;
    t_len              len_value;
    t_ctl_state        rx_phase;
    t_len              fill_pos;
    logic [BYTE_W-1:0] pay_store [MAX_PAYLOAD];
    logic              err_flag;
    logic [CNT_W-1:0]  pkt_count;
    t_result           due_results [$];

    int fails;
    int bytes_seen;
    int results_seen;
    int packets_seen;
    int cfg_writes;

    // Length 0 behaves as 1, anything past the store size as the store size
    function automatic int length_in_force();
        if (len_value == '0) begin
            return 1;
        end
        if (int'(len_value) > MAX_PAYLOAD) begin
            return MAX_PAYLOAD;
        end
        return int'(len_value);
    endfunction

    function automatic t_result make_result(logic done, t_idx idx, logic [BYTE_W-1:0] b,
                                            logic last);
        t_result r;
        r.done     = done;
        r.err      = err_flag;
        r.count    = pkt_count;
        r.idx      = idx;
        r.pay_byte = b;
        r.last     = last;
        return r;
    endfunction

    task automatic receive_byte(input logic [BYTE_W-1:0] b);
        int len;
        int pos;
        len = length_in_force();
        case (rx_phase)
            ST_COLLECT: begin
                pos = int'(fill_pos);
                if (pos < MAX_PAYLOAD) begin
                    pay_store[pos] = b;
                end
                pos++;
                fill_pos = t_len'(pos);
                if (pos >= len) begin
                    rx_phase = ST_TRAILER;
                end
            end
            ST_TRAILER: begin
                if (b == trl_value) begin
                    pkt_count++;
                    rx_phase = ST_IDLE;
                    for (int i = 0; i < len; i++) begin
                        due_results.push_back(make_result(1'b1, t_idx'(i), pay_store[i],
                                                          i == len - 1));
                    end
                    return;
                end
                // Wrong byte: overwrite the last slot and latch the error
                pay_store[len - 1] = b;
                err_flag = 1'b1;
            end
            default: begin
                if (b == hdr_value) begin
                    fill_pos = '0;
                    err_flag = 1'b0;
                    foreach (pay_store[i]) begin
                        pay_store[i] = '0;
                    end
                    rx_phase = ST_COLLECT;
                end else begin
                    rx_phase = ST_IDLE;
                end
            end
        endcase
        due_results.push_back(make_result(1'b0, '0, '0, 1'b1));
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            if (fails < REPORT_MAX) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        logic [OUT_PAD_W-1:0] pad;
        if (!i_rst_n) begin
            hdr_value = HEADER_RST;
            trl_value = TRAILER_RST;
            len_value = LENGTH_RST;
            rx_phase  = ST_IDLE;
            fill_pos  = '0;
            err_flag  = 1'b0;
            pkt_count = '0;
            foreach (pay_store[i]) begin
                pay_store[i] = '0;
            end
            due_results.delete();
            fails        = 0;
            bytes_seen   = 0;
            results_seen = 0;
            packets_seen = 0;
            cfg_writes   = 0;
        end else begin
            // Compare before predicting: a result never leaves in its byte's cycle
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    if (fails < REPORT_MAX) begin
                        $display("%0t: result with nothing expected, tdata %h tuser %b tlast %b",
                                 $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    end
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    pad  = i_m_tdata[OUT_DATA_W-1 -: OUT_PAD_W];
                    check_field("packet_done", 8'(want.done), 8'(i_m_tuser));
                    check_field("error_seen", 8'(want.err), 8'(i_m_tdata[0]));
                    check_field("packet_count", want.count, i_m_tdata[1 +: CNT_W]);
                    check_field("payload_index", 8'(want.idx), 8'(i_m_tdata[1+CNT_W +: IDX_W]));
                    check_field("payload_byte", want.pay_byte,
                                i_m_tdata[1+CNT_W+IDX_W +: BYTE_W]);
                    check_field("last", 8'(want.last), 8'(i_m_tlast));
                    check_field("tdata padding", 8'h00, 8'(pad));
                    if (want.done && want.last) begin
                        packets_seen++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cfg_writes++;
                case (t_cfg_index'(i_cfg_index))
                    CFG_HEADER:  hdr_value = i_cfg_data;
                    CFG_TRAILER: trl_value = i_cfg_data;
                    CFG_LENGTH:  len_value = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                bytes_seen++;
                receive_byte(i_s_tdata);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= due_results.size();
        o_bytes_seen   <= bytes_seen;
        o_results_seen <= results_seen;
        o_packets_seen <= packets_seen;
        o_cfg_writes   <= cfg_writes;
    end

endmodule

### verif/tb_framed_packet_receiver.sv
// ============================================================================
// tb_framed_packet_receiver - stimulus and verdict for the packet receiver
// Drives received bytes and register writes with random gaps and sink stalls:
// a directed opening, random framed packets under changing settings mixed
// with noise and broken frames, then a burst of back-to-back short packets.
// The checker beside the block judges every result.
// ============================================================================
module tb_framed_packet_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import frx_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 130;
    localparam int BURST_PACKETS = 12;
    localparam int TAIL_CYCLES   = 40;

    // Register index that maps to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [BYTE_W-1:0]     i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [BYTE_W-1:0]     i_cfg_data;

    int fail_count;
    int pending_count;
    int bytes_seen;
    int results_seen;
    int packets_seen;
    int cfg_writes;

    int   cycle_count  = 0;
    int   bytes_driven = 0;
    logic burst_mode   = 1'b0;

    logic [BYTE_W-1:0] cur_hdr;
    logic [BYTE_W-1:0] cur_trl;
    int                cur_len;

    framed_packet_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    frx_result_checker u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .i_m_tlast      (o_m_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_bytes_seen   (bytes_seen),
        .o_results_seen (results_seen),
        .o_packets_seen (packets_seen),
        .o_cfg_writes   (cfg_writes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none at all in burst mode
    function automatic int pick_gap();
        int r;
        if (burst_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int length_of(logic [BYTE_W-1:0] d);
        int l;
        l = int'(d[LEN_W-1:0]);
        if (l == 0) begin
            return 1;
        end
        return (l > MAX_PAYLOAD) ? MAX_PAYLOAD : l;
    endfunction

    // Mostly short lengths; zero, full store and oversize now and then
    function automatic logic [BYTE_W-1:0] pick_length_data();
        int r;
        t_len l;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            l = t_len'($urandom_range(1, 6));
        end else if (r < 70) begin
            l = t_len'($urandom_range(7, 15));
        end else if (r < 82) begin
            l = t_len'(MAX_PAYLOAD);
        end else if (r < 90) begin
            l = '0;
        end else begin
            l = t_len'($urandom_range(MAX_PAYLOAD + 1, 31));
        end
        return {3'($urandom_range(0, 7)), l};
    endfunction

    // Sink: random ready bursts and stalls
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    task automatic send_rx(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_driven++;
    endtask

    // Hold off the sender until every queued result has come out
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_packet(input int n_pay, input int n_wrong);
        logic [BYTE_W-1:0] w;
        send_rx(cur_hdr);
        repeat (n_pay) send_rx(8'($urandom_range(0, 255)));
        repeat (n_wrong) begin
            w = 8'($urandom_range(0, 255));
            if (w == cur_trl) begin
                w ^= 8'h01;
            end
            send_rx(w);
        end
        send_rx(cur_trl);
    endtask

    initial begin
        logic [BYTE_W-1:0] walk [8];
        logic [BYTE_W-1:0] len_data;
        int random_start;
        int kind;
        int k;
        int old_len;
        int more;

        walk = '{8'h00, 8'hFF, 8'hAA, 8'h55, TRAILER_RST, HEADER_RST, 8'h01, 8'h80};

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle bytes, one of them the trailer value
        send_rx(8'h00);
        send_rx(TRAILER_RST);
        // Full packet at reset length, framing values inside the payload
        send_rx(HEADER_RST);
        foreach (walk[i]) begin
            send_rx(walk[i]);
        end
        send_rx(TRAILER_RST);

        // Shortest packet, two wrong bytes before the trailer, sticky error after
        cfg_write(CFG_LENGTH, 8'd1);
        send_rx(HEADER_RST);
        send_rx(8'h7F);
        send_rx(8'h12);
        send_rx(8'h34);
        send_rx(TRAILER_RST);
        send_rx(8'h00);

        // Shrink the length mid-collect, then grow it while awaiting the trailer
        cfg_write(CFG_LENGTH, 8'd4);
        cfg_write(CFG_SPARE, 8'h5C);
        send_rx(HEADER_RST);
        send_rx(8'h11);
        send_rx(8'h22);
        send_rx(8'h33);
        cfg_write(CFG_LENGTH, 8'd2);
        send_rx(8'h44);
        cfg_write(CFG_LENGTH, 8'd6);
        send_rx(8'h66);
        send_rx(TRAILER_RST);

        random_start = bytes_driven;
        while (bytes_driven - random_start < RANDOM_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            cur_hdr    = 8'($urandom_range(0, 255));
            cur_trl    = ($urandom_range(0, 7) == 0) ? cur_hdr : 8'($urandom_range(0, 255));
            len_data   = pick_length_data();
            cur_len    = length_of(len_data);
            cfg_write(CFG_HEADER, cur_hdr);
            cfg_write(CFG_TRAILER, cur_trl);
            cfg_write(CFG_LENGTH, len_data);
            repeat ($urandom_range(3, 8)) begin
                kind = $urandom_range(0, 99);
                if (kind < 8) begin
                    drain();
                end
                if (kind < 70) begin
                    send_packet(cur_len, 0);
                end else if (kind < 82) begin
                    send_packet(cur_len, $urandom_range(1, 3));
                end else if (kind < 90) begin
                    // New length partway through a frame
                    k = $urandom_range(0, cur_len);
                    old_len = cur_len;
                    send_rx(cur_hdr);
                    repeat (k) send_rx(8'($urandom_range(0, 255)));
                    len_data = pick_length_data();
                    cur_len  = length_of(len_data);
                    cfg_write(CFG_LENGTH, len_data);
                    more = (k >= old_len) ? 0 : ((cur_len > k) ? cur_len - k : 1);
                    repeat (more) send_rx(8'($urandom_range(0, 255)));
                    send_rx(cur_trl);
                end else begin
                    // Noise, sometimes framing values out of place
                    repeat ($urandom_range(1, 4)) begin
                        k = $urandom_range(0, 9);
                        if (k < 2) begin
                            send_rx(cur_trl);
                        end else if (k < 3) begin
                            send_rx(cur_hdr);
                        end else begin
                            send_rx(8'($urandom_range(0, 255)));
                        end
                    end
                end
            end
        end

        // Back-to-back short packets
        burst_mode = 1'b1;
        cur_hdr    = 8'h00;
        cur_trl    = 8'hFF;
        cur_len    = 1;
        cfg_write(CFG_HEADER, cur_hdr);
        cfg_write(CFG_TRAILER, cur_trl);
        cfg_write(CFG_LENGTH, 8'hE1);
        repeat (BURST_PACKETS) send_packet(cur_len, 0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d bytes in, %0d results checked, %0d packets completed",
                 bytes_seen, results_seen, packets_seen);
        $display("%0d register writes: lengths 0 to 31, mid-frame changes, packet bursts",
                 cfg_writes);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
